// ----- rtl/core/hpq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the key compare for the binary heap priority queue.
// Used by hpq_ctrl, the top level and the checker; depends on nothing.
package hpq_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int ENTRY_W = 32;

    typedef enum logic [1:0] {
        REQ_ENQ    = 2'd0,
        REQ_DEQ    = 2'd1,
        REQ_CHANGE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] wdata;
    } ram_req_t;

    // True when entry a is served before entry b.
    function automatic logic goes_first(input logic [ENTRY_W-1:0] a,
                                        input logic [ENTRY_W-1:0] b,
                                        input logic order);
        logic [ENTRY_W-1:0] ka;
        logic [ENTRY_W-1:0] kb;
        ka = a ^ {1'b1, {(ENTRY_W-1){1'b0}}};
        kb = b ^ {1'b1, {(ENTRY_W-1){1'b0}}};
        return order ? (ka > kb) : (ka < kb);
    endfunction

endpackage

// ----- rtl/core/hpq_heap_ram.sv -----
`timescale 1ns / 1ps
// Single-port heap storage with a registered read port.
// Generic memory; depends on nothing.
module hpq_heap_ram #(
    parameter int AW = 10,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/core/hpq_ctrl.sv -----
`timescale 1ns / 1ps
// Request sequencer: sift up, sift down and id scans over the heap memory.
// Depends on hpq_pkg; drives hpq_heap_ram through a ram_req_t.
module hpq_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        heap_order,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_req_type,
    input  logic [15:0]                 s_patient_id,
    input  logic signed [15:0]          s_priority_req,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [15:0]                 m_out_id,
    output logic signed [15:0]          m_out_priority,
    output logic                        m_head_valid,
    output logic [15:0]                 m_head_id,
    output logic signed [15:0]          m_head_priority,
    output logic [hpq_pkg::CNT_W-1:0]   m_count,
    output hpq_pkg::ram_req_t           ram_req,
    input  logic [hpq_pkg::ENTRY_W-1:0] ram_rdata
);

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_DQ_TOP  = 15'b000000000000010,
        S_DQ_LAST = 15'b000000000000100,
        S_SD_LOAD = 15'b000000000001000,
        S_SD_L    = 15'b000000000010000,
        S_SD_R    = 15'b000000000100000,
        S_SD_CMP  = 15'b000000001000000,
        S_SU_CHK  = 15'b000000010000000,
        S_SU_CMP  = 15'b000000100000000,
        S_SC_RD   = 15'b000001000000000,
        S_SC_CK   = 15'b000010000000000,
        S_FS_RD   = 15'b000100000000000,
        S_FS_CK   = 15'b001000000000000,
        S_FIN     = 15'b010000000000000,
        S_FIN_W   = 15'b100000000000000
    } state_t;

    state_t                            state_reg, state_next;
    logic [hpq_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [hpq_pkg::ADDR_W-1:0]        pos_reg, pos_next;
    logic [hpq_pkg::ADDR_W-1:0]        where_reg, where_next;
    logic [hpq_pkg::CNT_W-1:0]         idx_reg, idx_next;
    logic                              found_reg, found_next;
    logic                              chg_reg, chg_next;
    logic [hpq_pkg::ENTRY_W-1:0]       cur_reg, cur_next;
    logic [hpq_pkg::ENTRY_W-1:0]       left_reg, left_next;
    logic [15:0]                       id_reg, id_next;
    hpq_pkg::status_t                  status_reg, status_next;
    logic [hpq_pkg::ENTRY_W-1:0]       rem_reg, rem_next;
    logic                              m_valid_reg;
    logic [1:0]                        m_status_reg;
    logic [hpq_pkg::ENTRY_W-1:0]       m_rem_reg;
    logic                              m_head_valid_reg;
    logic [hpq_pkg::ENTRY_W-1:0]       m_head_reg;
    logic [hpq_pkg::CNT_W-1:0]         m_count_reg;
    logic                              out_load;

    logic [hpq_pkg::CNT_W:0]           left_w, right_w, count_w;
    logic [hpq_pkg::ADDR_W-1:0]        parent;
    logic                              right_ok;
    logic                              take_l, take_r;
    logic [hpq_pkg::ENTRY_W-1:0]       best_l;

    assign count_w  = {1'b0, count_reg};
    assign left_w   = {1'b0, pos_reg, 1'b1};
    assign right_w  = left_w + 1'b1;
    assign right_ok = right_w < count_w;
    assign parent   = (pos_reg - 1'b1) >> 1;
    assign take_l   = hpq_pkg::goes_first(left_reg, cur_reg, heap_order);
    assign best_l   = take_l ? left_reg : cur_reg;
    assign take_r   = right_ok && hpq_pkg::goes_first(ram_rdata, best_l, heap_order);

    assign s_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_FIN_W) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        where_next    = where_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        chg_next      = chg_reg;
        cur_next      = cur_reg;
        left_next     = left_reg;
        id_next       = id_reg;
        status_next   = status_reg;
        rem_next      = rem_reg;
        ram_req.we    = 1'b0;
        ram_req.addr  = '0;
        ram_req.wdata = cur_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    status_next = hpq_pkg::ST_OK;
                    rem_next    = '0;
                    chg_next    = 1'b0;
                    id_next     = s_patient_id;
                    cur_next    = {s_priority_req, s_patient_id};
                    case (hpq_pkg::req_t'(s_req_type))
                        hpq_pkg::REQ_ENQ: begin
                            if (count_reg >= hpq_pkg::CNT_W'(hpq_pkg::DEPTH)) begin
                                status_next = hpq_pkg::ST_FULL;
                                state_next  = S_FIN;
                            end else begin
                                pos_next   = count_reg[hpq_pkg::ADDR_W-1:0];
                                count_next = count_reg + 1'b1;
                                state_next = S_SU_CHK;
                            end
                        end
                        hpq_pkg::REQ_DEQ: begin
                            if (count_reg == '0) begin
                                status_next = hpq_pkg::ST_EMPTY;
                                state_next  = S_FIN;
                            end else begin
                                state_next = S_DQ_TOP;
                            end
                        end
                        hpq_pkg::REQ_CHANGE: begin
                            chg_next   = 1'b1;
                            idx_next   = '0;
                            found_next = 1'b0;
                            state_next = S_SC_RD;
                        end
                        default: begin
                            count_next = '0;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_DQ_TOP: begin
                ram_req.addr = '0;
                state_next   = S_DQ_LAST;
            end
            S_DQ_LAST: begin
                rem_next     = ram_rdata;
                count_next   = count_reg - 1'b1;
                ram_req.addr = count_next[hpq_pkg::ADDR_W-1:0];
                state_next   = (count_next == '0) ? S_FIN : S_SD_LOAD;
            end
            S_SD_LOAD: begin
                cur_next   = ram_rdata;
                pos_next   = '0;
                state_next = S_SD_L;
            end
            S_SD_L: begin
                if (left_w < count_w) begin
                    ram_req.addr = left_w[hpq_pkg::ADDR_W-1:0];
                    state_next   = S_SD_R;
                end else begin
                    ram_req.we   = 1'b1;
                    ram_req.addr = pos_reg;
                    state_next   = S_FIN;
                end
            end
            S_SD_R: begin
                left_next    = ram_rdata;
                ram_req.addr = right_w[hpq_pkg::ADDR_W-1:0];
                state_next   = S_SD_CMP;
            end
            S_SD_CMP: begin
                ram_req.we   = 1'b1;
                ram_req.addr = pos_reg;
                if (take_r) begin
                    ram_req.wdata = ram_rdata;
                    pos_next      = right_w[hpq_pkg::ADDR_W-1:0];
                    state_next    = S_SD_L;
                end else if (take_l) begin
                    ram_req.wdata = left_reg;
                    pos_next      = left_w[hpq_pkg::ADDR_W-1:0];
                    state_next    = S_SD_L;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_SU_CHK: begin
                if (pos_reg == '0) begin
                    ram_req.we   = 1'b1;
                    ram_req.addr = pos_reg;
                    idx_next     = '0;
                    state_next   = chg_reg ? S_FS_RD : S_FIN;
                end else begin
                    ram_req.addr = parent;
                    state_next   = S_SU_CMP;
                end
            end
            S_SU_CMP: begin
                ram_req.we   = 1'b1;
                ram_req.addr = pos_reg;
                if (hpq_pkg::goes_first(cur_reg, ram_rdata, heap_order)) begin
                    ram_req.wdata = ram_rdata;
                    pos_next      = parent;
                    state_next    = S_SU_CHK;
                end else begin
                    idx_next   = '0;
                    state_next = chg_reg ? S_FS_RD : S_FIN;
                end
            end
            S_SC_RD: begin
                if (idx_reg < count_reg) begin
                    ram_req.addr = idx_reg[hpq_pkg::ADDR_W-1:0];
                    state_next   = S_SC_CK;
                end else if (found_reg) begin
                    pos_next   = where_reg;
                    state_next = S_SU_CHK;
                end else begin
                    status_next = hpq_pkg::ST_NOT_FOUND;
                    state_next  = S_FIN;
                end
            end
            S_SC_CK: begin
                if (ram_rdata[15:0] == id_reg) begin
                    found_next = 1'b1;
                    where_next = idx_reg[hpq_pkg::ADDR_W-1:0];
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_SC_RD;
            end
            S_FS_RD: begin
                ram_req.addr = idx_reg[hpq_pkg::ADDR_W-1:0];
                state_next   = S_FS_CK;
            end
            S_FS_CK: begin
                if (ram_rdata == cur_reg) begin
                    pos_next   = idx_reg[hpq_pkg::ADDR_W-1:0];
                    state_next = S_SD_L;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FS_RD;
                end
            end
            S_FIN: begin
                ram_req.addr = '0;
                state_next   = S_FIN_W;
            end
            S_FIN_W: begin
                ram_req.addr = '0;
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        where_reg  <= where_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        chg_reg    <= chg_next;
        cur_reg    <= cur_next;
        left_reg   <= left_next;
        id_reg     <= id_next;
        status_reg <= status_next;
        rem_reg    <= rem_next;
        if (out_load) begin
            m_status_reg     <= status_reg;
            m_rem_reg        <= rem_reg;
            m_head_valid_reg <= (count_reg != '0);
            m_head_reg       <= (count_reg != '0) ? ram_rdata : '0;
            m_count_reg      <= count_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_out_id        = m_rem_reg[15:0];
    assign m_out_priority  = m_rem_reg[31:16];
    assign m_head_valid    = m_head_valid_reg;
    assign m_head_id       = m_head_reg[15:0];
    assign m_head_priority = m_head_reg[31:16];
    assign m_count         = m_count_reg;

endmodule

// ----- rtl/core/binary_heap_priority_queue_core.sv -----
`timescale 1ns / 1ps
// Binary heap priority queue: top level with APB configuration, sequencer and heap memory.
// Depends on hpq_pkg, hpq_ctrl and hpq_heap_ram.
// Enqueue sifts the new entry up; dequeue moves the last entry to the root and sifts it down.
// A priority change scans for the id and sifts up, then rescans for the entry and sifts down.
// One request is in flight at a time; the single memory port sets every step.
// Synchronous active-low reset empties the queue and selects min order; memory is not cleared.
module binary_heap_priority_queue_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_req_type,
    input  logic [15:0]               s_patient_id,
    input  logic signed [15:0]        s_priority_req,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [15:0]               m_out_id,
    output logic signed [15:0]        m_out_priority,
    output logic                      m_head_valid,
    output logic [15:0]               m_head_id,
    output logic signed [15:0]        m_head_priority,
    output logic [hpq_pkg::CNT_W-1:0] m_count
);

    logic                        heap_order_reg;
    hpq_pkg::ram_req_t           ram_req;
    logic [hpq_pkg::ENTRY_W-1:0] ram_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'b0, heap_order_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_order_reg <= 1'b0;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            heap_order_reg <= pwdata[0];
        end
    end

    hpq_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .heap_order      (heap_order_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_patient_id    (s_patient_id),
        .s_priority_req  (s_priority_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_id        (m_out_id),
        .m_out_priority  (m_out_priority),
        .m_head_valid    (m_head_valid),
        .m_head_id       (m_head_id),
        .m_head_priority (m_head_priority),
        .m_count         (m_count),
        .ram_req         (ram_req),
        .ram_rdata       (ram_rdata)
    );

    hpq_heap_ram #(
        .AW (hpq_pkg::ADDR_W),
        .DW (hpq_pkg::ENTRY_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

endmodule

// ----- rtl/core/hpq_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the priority queue core, bound to the top level.
// Depends on hpq_pkg and binary_heap_priority_queue_core.
module hpq_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [1:0]                m_status,
    input logic [15:0]               m_out_id,
    input logic                      m_head_valid,
    input logic [hpq_pkg::CNT_W-1:0] m_count
);

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("core accepted a request while one is in progress");

    a_head_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_head_valid == (m_count != '0)))
        else $error("head valid disagrees with count");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == hpq_pkg::ST_EMPTY) |-> (m_count == '0) && (m_out_id == '0))
        else $error("empty status with entries held");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == hpq_pkg::ST_FULL)
            |-> (m_count == hpq_pkg::CNT_W'(hpq_pkg::DEPTH)))
        else $error("full status below capacity");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_count) && $stable(m_status))
        else $error("result changed while stalled");

endmodule

bind binary_heap_priority_queue_core hpq_checker u_hpq_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_out_id     (m_out_id),
    .m_head_valid (m_head_valid),
    .m_count      (m_count)
);
